### rtl/key_short_long_press_tracker_defines.svh
// assertion macros used by the tracker module
`ifndef KEY_SHORT_LONG_PRESS_TRACKER_DEFINES_SVH
`define KEY_SHORT_LONG_PRESS_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked on every clock edge outside reset
`define KSPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key tracker check failed");
// next-cycle implication
`define KSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key tracker check failed");
`else
`define KSPT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/kspt_pkg.sv
package kspt_pkg;

    localparam int NUM_KEYS_DEF = 16;
    localparam int KEY_W        = 4;
    localparam int TIME_W       = 32;
    localparam int THR_W        = 16;

    localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd2000;

    typedef enum logic [1:0] {
        KS_RELEASED = 2'd0,
        KS_PRESSED  = 2'd1,
        KS_SHORT    = 2'd2,
        KS_LONG     = 2'd3
    } t_key_state;

    typedef struct packed {
        t_key_state              st;
        logic [TIME_W-1:0]       start_ms;
    } t_entry;

endpackage

### rtl/key_short_long_press_tracker.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------
// sample    | in        | start, busy          | i_key_index, i_pressed, i_now_ms
// result    | out       | o_valid (strobe)     | o_key_id, o_key_state
// config    | in        | i_cfg_wr_en          | i_cfg_wr_data (long_press_ms)
//
// one sample per cycle; its result strobe rises at the edge after the accepting edge
// the accepting edge reads the key table memory, the next edge writes it back
// a write-back is forwarded to the following sample, so busy stays low
// reset is synchronous; per-key valid bits make every entry read as released
// the receiver cannot stall: each result is shown for exactly one cycle
module key_short_long_press_tracker #(
    parameter int NUM_KEYS = kspt_pkg::NUM_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [kspt_pkg::KEY_W-1:0]  i_key_index,
    input  logic                        i_pressed,
    input  logic [kspt_pkg::TIME_W-1:0] i_now_ms,
    input  logic                        i_cfg_wr_en,
    input  logic [kspt_pkg::THR_W-1:0]  i_cfg_wr_data,
    output logic                        o_valid,
    output logic [kspt_pkg::KEY_W-1:0]  o_key_id,
    output logic [1:0]                  o_key_state
);
    import kspt_pkg::*;

`include "key_short_long_press_tracker_defines.svh"

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // key table
    t_entry                  mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]     r_ent_vld;

    logic                    accept;
    logic                    in_range;
    logic [AW-1:0]           rd_addr;

    logic [THR_W-1:0]        r_thr;

    // read stage
    logic                    r_s1_vld;
    logic                    r_s1_inr;
    logic [AW-1:0]           r_s1_addr;
    logic [KEY_W-1:0]        r_s1_key;
    logic                    r_s1_pressed;
    logic [TIME_W-1:0]       r_s1_now;
    t_entry                  r_rd;
    logic                    r_rd_vld;

    // write-back forwarding
    logic                    r_fw_vld;
    logic [AW-1:0]           r_fw_addr;
    t_entry                  r_fw_entry;

    t_entry                  cur;
    t_entry                  n_entry;
    logic [TIME_W-1:0]       elapsed;
    logic                    wr_en;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign in_range = (32'(i_key_index) < NUM_KEYS);
    assign rd_addr  = AW'(i_key_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= LONG_PRESS_RST;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_inr     <= in_range;
            r_s1_addr    <= rd_addr;
            r_s1_key     <= i_key_index;
            r_s1_pressed <= i_pressed;
            r_s1_now     <= i_now_ms;
        end
    end

    // synchronous read: the entry is registered on the accepting edge
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_rd     <= mem[rd_addr];
            r_rd_vld <= r_ent_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_addr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (wr_en) begin
            r_ent_vld[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fw_addr  <= r_s1_addr;
            r_fw_entry <= n_entry;
        end
    end

    assign wr_en = r_s1_vld && r_s1_inr;

    // the previous write-back landed on the same edge as this read
    always_comb begin
        if (r_fw_vld && (r_fw_addr == r_s1_addr)) begin
            cur = r_fw_entry;
        end else if (r_rd_vld) begin
            cur = r_rd;
        end else begin
            cur = '{st: KS_RELEASED, start_ms: '0};
        end
    end

    assign elapsed = r_s1_now - cur.start_ms;

    always_comb begin
        n_entry = cur;
        case (cur.st)
            KS_RELEASED: begin
                if (r_s1_pressed) begin
                    n_entry.st       = KS_PRESSED;
                    n_entry.start_ms = r_s1_now;
                end
            end
            KS_PRESSED: begin
                if (!r_s1_pressed) begin
                    n_entry.st = (elapsed < {{(TIME_W-THR_W){1'b0}}, r_thr}) ?
                                 KS_SHORT : KS_LONG;
                end
            end
            default: begin
                // short or long: a new press also covers a missed release
                if (r_s1_pressed) begin
                    n_entry.st       = KS_PRESSED;
                    n_entry.start_ms = r_s1_now;
                end else begin
                    n_entry.st       = KS_RELEASED;
                    n_entry.start_ms = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            o_key_id    <= r_s1_key;
            o_key_state <= r_s1_inr ? n_entry.st : KS_RELEASED;
        end
    end

    `KSPT_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, r_s1_vld)
    `KSPT_ASSERT_NEXT(a_oor_released, i_clk, i_rst_n, r_s1_vld && !r_s1_inr,
                      o_key_state == KS_RELEASED)
    `KSPT_ASSERT_NEXT(a_release_classified, i_clk, i_rst_n,
                      wr_en && (cur.st == KS_PRESSED) && !r_s1_pressed,
                      (o_key_state == KS_SHORT) || (o_key_state == KS_LONG))
    `KSPT_ASSERT_SAME(a_fw_only_after_write, i_clk, i_rst_n, r_fw_vld, $past(wr_en))

endmodule
